>>> rtl/dtcc_pkg.sv
package dtcc_pkg;

	localparam int unsigned NUM_STAGES = 15;
	localparam int unsigned DIV_STAGES = 10;
	localparam int unsigned DIV_STEPS  = 2;
	localparam int unsigned DIV_FIRST  = NUM_STAGES - DIV_STAGES + 1;

	localparam int unsigned IN_W    = 32;
	localparam int unsigned CLK_W   = 28;
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned ACT_W   = 20;
	localparam int unsigned TICK_W  = 10;
	localparam int unsigned OUT_W   = 32;

	localparam logic [CLK_W-1:0] CLK_FLOOR_HZ = 28'd1000000;
	localparam logic [CLK_W-1:0] CLK_RESET_HZ = 28'd72000000;
	localparam logic [39:0]      SAT_PRODUCT  = 40'd1009000000000;
	localparam logic [11:0]      RECIP_ODD    = 12'd2199;
	localparam logic [20:0]      NS_ODD       = 21'd1953125;
	localparam logic [29:0]      NS_PER_S     = 30'd1000000000;
	localparam logic [TICK_W-1:0] MAX_TICKS   = 10'd1008;

	localparam logic [CODE_W-1:0] CODE_R1   = 8'h80;
	localparam logic [CODE_W-1:0] CODE_R2   = 8'hC0;
	localparam logic [CODE_W-1:0] CODE_R3   = 8'hE0;
	localparam logic [CODE_W-1:0] MASK_R1   = 8'h3F;
	localparam logic [CODE_W-1:0] MASK_R23  = 8'h1F;

	function automatic logic [CODE_W-1:0] encode_ticks(input logic [TICK_W-1:0] t);
		logic [10:0] up;
		logic [CODE_W-1:0] code;
		up = '0;
		priority if (t <= 10'd127) begin
			code = t[7:0];
		end else if (t <= 10'd254) begin
			up = (11'(t) + 11'd1) >> 1;
			code = CODE_R1 | (8'(up - 11'd64) & MASK_R1);
		end else if (t <= 10'd504) begin
			up = (11'(t) + 11'd7) >> 3;
			code = CODE_R2 | (8'(up - 11'd32) & MASK_R23);
		end else begin
			up = (11'(t) + 11'd15) >> 4;
			code = CODE_R3 | (8'(up - 11'd32) & MASK_R23);
		end
		return code;
	endfunction

	function automatic logic [TICK_W-1:0] decode_code(input logic [CODE_W-1:0] c);
		logic [TICK_W-1:0] t;
		priority if (c[7] == 1'b0) begin
			t = 10'(c);
		end else if (c[6] == 1'b0) begin
			t = 10'((11'd64 + 11'(c & MASK_R1)) << 1);
		end else if (c[5] == 1'b0) begin
			t = 10'((11'd32 + 11'(c & MASK_R23)) << 3);
		end else begin
			t = 10'((11'd32 + 11'(c & MASK_R23)) << 4);
		end
		return t;
	endfunction

endpackage

>>> rtl/dead_time_code_converter_core.sv
// Throughput: one item per cycle; each stage holds only when it is full and
// the stage after it cannot take its item, so bubbles close up under a stall.
// The depth is set by the product, the constant divide, the encode, the decode
// and the 20-bit divide by the clock (ten stages, two quotient bits each).
// Reset (arst_n low): all stages empty, timer clock register back to 72 MHz.
module dead_time_code_converter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dtcc_pkg::CLK_W-1:0]  cfg_wr_data,  // timer_clock_hz
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [dtcc_pkg::IN_W-1:0]   s_axis_tdata,  // [31:0] target_ns
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [dtcc_pkg::OUT_W-1:0]  m_axis_tdata   // [7:0] dead_time_code, [27:8] achieved_ns
);
	import dtcc_pkg::*;

	logic [CLK_W-1:0]      clk_eff_q;
	logic [NUM_STAGES:1]   vld_s;
	logic [NUM_STAGES:1]   en;

	logic [59:0]           prod_s1;
	logic [30:0]           a_s2;
	logic [10:0]           q0_s2;
	logic                  sat_s2;
	logic [21:0]           r_s3;
	logic [10:0]           q0_s3;
	logic                  sat_s3;
	logic [CODE_W-1:0]     code_s4;

	logic [CLK_W-1:0]      div_rem_s  [DIV_STAGES+1];
	logic [ACT_W-1:0]      div_lq_s   [DIV_STAGES+1];
	logic [CODE_W-1:0]     div_code_s [DIV_STAGES+1];

	logic [42:0]           recip_prod;
	logic [31:0]           qd_prod;
	logic [TICK_W-1:0]     ticks;
	logic [39:0]           num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_eff_q <= CLK_RESET_HZ;
		end else if (cfg_wr_en) begin
			clk_eff_q <= (cfg_wr_data < CLK_FLOOR_HZ) ? CLK_FLOOR_HZ : cfg_wr_data;
		end
	end

	always_comb begin
		en[NUM_STAGES] = !vld_s[NUM_STAGES] || m_axis_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign recip_prod = 43'(prod_s1[39:9]) * 43'(RECIP_ODD);

	assign qd_prod = 32'(q0_s2) * 32'(NS_ODD);

	always_comb begin
		priority if (sat_s3) begin
			ticks = MAX_TICKS;
		end else if (r_s3 >= 22'(NS_ODD)) begin
			ticks = 10'(q0_s3 + 11'd1);
		end else begin
			ticks = 10'(q0_s3);
		end
	end

	assign num = 40'(decode_code(code_s4)) * 40'(NS_PER_S);

	always_ff @(posedge clk) begin
		if (en[1]) prod_s1 <= 60'(s_axis_tdata) * 60'(clk_eff_q);
		if (en[2]) begin
			a_s2   <= prod_s1[39:9];
			q0_s2  <= recip_prod[42:32];
			sat_s2 <= prod_s1 >= 60'(SAT_PRODUCT);
		end
		if (en[3]) begin
			r_s3   <= 22'(32'(a_s2) - qd_prod);
			q0_s3  <= q0_s2;
			sat_s3 <= sat_s2;
		end
		if (en[4]) code_s4 <= encode_ticks(ticks);
		if (en[5]) begin
			div_rem_s[0]  <= CLK_W'(num[39:20]);
			div_lq_s[0]   <= num[19:0];
			div_code_s[0] <= code_s4;
		end
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [CLK_W-1:0]  rem;
		logic [ACT_W-1:0]  lq;
		logic [CLK_W:0]    trial;
		logic [CLK_W:0]    diff;
		logic              ge;

		always_comb begin
			rem   = div_rem_s[j];
			lq    = div_lq_s[j];
			trial = '0;
			diff  = '0;
			ge    = 1'b0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				trial = {rem, lq[ACT_W-1]};
				diff  = trial - {1'b0, clk_eff_q};
				ge    = trial >= {1'b0, clk_eff_q};
				rem   = ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
				lq    = {lq[ACT_W-2:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en[DIV_FIRST+j]) begin
				div_rem_s[j+1]  <= rem;
				div_lq_s[j+1]   <= lq;
				div_code_s[j+1] <= div_code_s[j];
			end
		end
	end

	assign m_axis_tvalid = vld_s[NUM_STAGES];
	assign m_axis_tdata  = {(OUT_W - ACT_W - CODE_W)'(0), div_lq_s[DIV_STAGES],
		div_code_s[DIV_STAGES]};

endmodule

>>> rtl/dtcc_checker.sv
module dtcc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tready,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [dtcc_pkg::OUT_W-1:0]  m_axis_tdata
);
	import dtcc_pkg::*;

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output item changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:ACT_W+CODE_W] == '0)
		else $error("padding bits of output item not zero");

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[CODE_W-1:0] == '0
		|-> m_axis_tdata[ACT_W+CODE_W-1:CODE_W] == '0)
		else $error("zero code with nonzero dead time");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage empty");

endmodule

bind dead_time_code_converter_core dtcc_checker u_dtcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> verif/dead_time_checker.sv
module dead_time_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [dtcc_pkg::CLK_W-1:0] cfg_wr_data,    // timer_clock_hz
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [dtcc_pkg::IN_W-1:0]  s_axis_tdata,   // [31:0] target_ns
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [dtcc_pkg::OUT_W-1:0] m_axis_tdata,   // [7:0] dead_time_code, [27:8] achieved_ns
	output int                         mismatch_count,
	output int                         pending_count
);
	import dtcc_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [ACT_W-1:0]  achieved_ns;
	} dead_time_t;

	dead_time_t       expected_dead_times[$];
	logic [CLK_W-1:0] timer_clock_hz;
	int               errors = 0;

	function automatic dead_time_t predict_dead_time(input logic [IN_W-1:0] target_ns,
			input logic [CLK_W-1:0] clock_hz);
		longint unsigned hz;
		longint unsigned ticks;
		longint unsigned step;
		longint unsigned units;
		longint unsigned decoded;
		dead_time_t      result;
		hz = (clock_hz < CLK_FLOOR_HZ) ? 64'(CLK_FLOOR_HZ) : 64'(clock_hz);
		ticks = (64'(target_ns) * hz) / 64'(NS_PER_S);
		if (ticks > 64'(MAX_TICKS)) begin
			ticks = 64'(MAX_TICKS);
		end
		if (ticks <= 127) begin
			result.code = 8'(ticks);
			decoded = ticks;
		end else begin
			// round up to the step of the coarser range
			if (ticks <= 254) begin
				step = 2;
			end else if (ticks <= 504) begin
				step = 8;
			end else begin
				step = 16;
			end
			units = (ticks + step - 1) / step;
			decoded = units * step;
			case (step)
				2: result.code = CODE_R1 | 8'(units - 64);
				8: result.code = CODE_R2 | 8'(units - 32);
				default: result.code = CODE_R3 | 8'(units - 32);
			endcase
		end
		result.achieved_ns = 20'((decoded * 64'(NS_PER_S)) / hz);
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dead_time_t        want;
		logic [CODE_W-1:0] got_code;
		logic [ACT_W-1:0]  got_achieved;
		if (!arst_n) begin
			timer_clock_hz <= CLK_RESET_HZ;
			expected_dead_times.delete();
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_code = m_axis_tdata[CODE_W-1:0];
				got_achieved = m_axis_tdata[CODE_W +: ACT_W];
				if (expected_dead_times.size() == 0) begin
					$error("unexpected item: dead_time_code %0d, achieved_ns %0d",
						got_code, got_achieved);
					errors++;
				end else begin
					want = expected_dead_times.pop_front();
					if (got_code !== want.code) begin
						$error("dead_time_code: expected %0d, got %0d", want.code, got_code);
						errors++;
					end
					if (got_achieved !== want.achieved_ns) begin
						$error("achieved_ns: expected %0d, got %0d", want.achieved_ns,
							got_achieved);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_dead_times.push_back(predict_dead_time(s_axis_tdata, timer_clock_hz));
			end
			if (cfg_wr_en) begin
				timer_clock_hz <= cfg_wr_data;
			end
			pending_count <= expected_dead_times.size();
		end
		mismatch_count <= errors;
	end

endmodule

>>> verif/testbench.sv
module testbench;
	import dtcc_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CLK_W-1:0] cfg_wr_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // [31:0] target_ns
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // [7:0] dead_time_code, [27:8] achieved_ns
	int               mismatch_count;
	int               pending_count;

	logic [CLK_W-1:0] clock_hz;
	logic [CLK_W-1:0] phase_hz [0:8];
	int               burst_left = 0;
	int               gap;
	int unsigned      boundary_ticks [19] = '{0, 1, 2, 127, 128, 129, 130, 253, 254, 255,
		256, 257, 503, 504, 505, 506, 1007, 1008, 1009};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dead_time_code_converter_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	dead_time_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	function automatic logic [IN_W-1:0] ns_for_ticks(input int unsigned ticks);
		longint unsigned hz;
		hz = (clock_hz < CLK_FLOOR_HZ) ? 64'(CLK_FLOOR_HZ) : 64'(clock_hz);
		return 32'((64'(ticks) * 64'(NS_PER_S) + hz - 1) / hz);
	endfunction

	function automatic logic [IN_W-1:0] random_request();
		logic [IN_W-1:0] ns;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// land on either side of a tick boundary
				ns = ns_for_ticks($urandom_range(0, 1100));
				if ($urandom_range(0, 1) == 1 && ns != 0) begin
					ns = ns - 1;
				end
			end
			4, 5, 6: ns = $urandom_range(0, ns_for_ticks(1100));
			7, 8: ns = $urandom();
			default: ns = $urandom_range(0, 255);
		endcase
		return ns;
	endfunction

	task automatic send_request(input logic [IN_W-1:0] ns);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ns;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_clock(input logic [CLK_W-1:0] hz);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clock_hz = hz;
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			int mode;
			int span;
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 200);
			for (int phase = 0; phase < span; phase++) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (phase % 4) != 3;
					default: m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		clock_hz = CLK_RESET_HZ;
		phase_hz[0] = 28'd1000000;
		phase_hz[1] = 28'd200000000;
		phase_hz[2] = 28'd0;
		phase_hz[3] = 28'd999999;
		phase_hz[4] = 28'hFFFFFFF;
		phase_hz[5] = 28'd168000000;
		phase_hz[6] = 28'($urandom_range(1000000, 200000000));
		phase_hz[7] = 28'($urandom());
		phase_hz[8] = CLK_RESET_HZ;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (boundary_ticks[i]) begin
			send_request(ns_for_ticks(boundary_ticks[i]));
		end
		send_request(32'hFFFFFFFF);
		send_request(32'h80000000);
		send_request(32'hAAAAAAAA);
		send_request(32'h55555555);
		repeat (150) send_request(random_request());

		foreach (phase_hz[p]) begin
			write_clock(phase_hz[p]);
			repeat (170) send_request(random_request());
		end

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
rtl/dtcc_pkg.sv
rtl/dead_time_code_converter_core.sv
rtl/dtcc_checker.sv
verif/dead_time_checker.sv
verif/testbench.sv
